@@ hdl/spl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spl_pkg
// shared widths, register codes and types of the spotlight fragment shader
// ----------------------------------------------------------------------------
package spl_pkg;

  // vector normalize unit
  localparam int VEC_W    = 39;              // signed component width at the unit input
  localparam int POS_W    = 6;               // leading-one position of a VEC_W word
  localparam int NRM_SH   = 23;              // largest magnitude lands in [2^23, 2^24)
  localparam int MN_W     = 24;              // normalized magnitude width
  localparam int SQ_W     = 2 * MN_W + 2;    // sum of three squares
  localparam int ROOT_W   = SQ_W / 2;        // square root width
  localparam int REM_W    = ROOT_W + 3;      // square root remainder width
  localparam int SQ_N     = ROOT_W;          // one root bit per stage
  localparam int DV_N     = 15;              // quotient bits of the unit divide
  localparam int DVR_W    = ROOT_W + 1;      // partial remainder of the unit divide
  localparam int UNIT_W   = 16;              // signed Q1.14 unit component
  localparam int UNIT_LAT = SQ_N + DV_N + 7; // register stages in the unit

  // fixed point
  localparam int ONE_Q14     = 16384;
  localparam int AMBIENT_Q14 = 1311;
  localparam int CD_N        = 14;           // quotient bits of the cone divide

  // ports
  localparam int CFG_AW = 3;
  localparam int CFG_W  = 60;
  localparam int IN_W   = 184;
  localparam int OUT_W  = 24;

  typedef enum logic [CFG_AW-1:0] {
    REG_LIGHT_DIR   = 3'd0,
    REG_LIGHT_POS   = 3'd1,
    REG_OUTER_COS   = 3'd2,
    REG_CONE_EPS    = 3'd3,
    REG_LIGHT_COLOR = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SHADE = 1'b1
  } cmd_t;

  typedef logic signed [VEC_W-1:0]  vec_comp_t;
  typedef logic signed [UNIT_W-1:0] unit_comp_t;

endpackage
`default_nettype wire

@@ hdl/spl_unit3.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spl_unit3
// pipelined normalize of a signed 3-vector to Q1.14 unit components
// ----------------------------------------------------------------------------
module spl_unit3
  import spl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire vec_comp_t  vec_i  [3],
  output unit_comp_t      unit_o [3]
);

  // stage 1: magnitudes
  logic [VEC_W-1:0] mag_c [3];
  logic [VEC_W-1:0] mag1_r [3];
  logic [2:0]       neg1_r;
  logic [VEC_W-1:0] orv1_r;

  // stage 2: leading one
  logic [POS_W-1:0] pos_c;
  logic [VEC_W-1:0] mag2_r [3];
  logic [2:0]       neg2_r;
  logic [POS_W-1:0] pos2_r;
  logic             zero2_r;

  // stage 3: shift
  logic [VEC_W+NRM_SH-1:0] wide_c [3];
  logic [MN_W-1:0]  mn3_r [3];
  logic [2:0]       neg3_r;
  logic             zero3_r;

  // stage 4: squares
  logic [2*MN_W-1:0] sq4_r [3];
  logic [MN_W-1:0]   mn4_r [3];
  logic [2:0]        neg4_r;
  logic              zero4_r;

  // square root stages, index 0 holds the sum
  logic [SQ_W-1:0]   rad_r   [SQ_N+1];
  logic [REM_W-1:0]  rem_r   [SQ_N+1];
  logic [ROOT_W-1:0] root_r  [SQ_N+1];
  logic [MN_W-1:0]   mnq_r   [SQ_N+1][3];
  logic [2:0]        negq_r  [SQ_N+1];
  logic              zq_r    [SQ_N+1];
  logic [SQ_W-1:0]   rad_nxt  [SQ_N+1];
  logic [REM_W-1:0]  rem_nxt  [SQ_N+1];
  logic [ROOT_W-1:0] root_nxt [SQ_N+1];

  // divide stages, index 0 holds the loaded numerator
  logic [DVR_W-1:0]  dr_r   [DV_N+1][3];
  logic [DV_N-1:0]   nb_r   [DV_N+1][3];
  logic [DV_N-1:0]   dq_r   [DV_N+1][3];
  logic [ROOT_W-1:0] dlen_r [DV_N+1];
  logic [2:0]        dneg_r [DV_N+1];
  logic              dz_r   [DV_N+1];
  logic [DVR_W-1:0]  dr_nxt [DV_N+1][3];
  logic [DV_N-1:0]   dq_nxt [DV_N+1][3];

  logic [DV_N-1:0]   qc_c [3];
  unit_comp_t        unit_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_i[i][VEC_W-1] ? VEC_W'(-vec_i[i]) : VEC_W'(vec_i[i]);
    end
  end

  // highest set bit of the or of all magnitudes is that of the largest one
  always_comb begin
    pos_c = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (orv1_r[b]) begin
        pos_c = POS_W'(b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide_c[i] = {mag2_r[i], NRM_SH'(0)} >> pos2_r;
    end
  end

  // one root bit per stage
  always_comb begin
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    rad_nxt[0]  = '0;
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
    rem_t       = '0;
    trial       = '0;
    for (int k = 1; k <= SQ_N; k++) begin
      rem_t = {rem_r[k-1][REM_W-3:0], rad_r[k-1][SQ_W-1 -: 2]};
      trial = REM_W'({root_r[k-1], 2'b01});
      rad_nxt[k] = rad_r[k-1] << 2;
      if (rem_t >= trial) begin
        rem_nxt[k]  = rem_t - trial;
        root_nxt[k] = {root_r[k-1][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_t;
        root_nxt[k] = {root_r[k-1][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // one quotient bit per stage
  always_comb begin
    logic [DVR_W-1:0] rt;
    rt = '0;
    for (int i = 0; i < 3; i++) begin
      dr_nxt[0][i] = '0;
      dq_nxt[0][i] = '0;
    end
    for (int j = 1; j <= DV_N; j++) begin
      for (int i = 0; i < 3; i++) begin
        rt = {dr_r[j-1][i][DVR_W-2:0], nb_r[j-1][i][DV_N-1]};
        if (rt >= DVR_W'(dlen_r[j-1])) begin
          dr_nxt[j][i] = rt - DVR_W'(dlen_r[j-1]);
          dq_nxt[j][i] = {dq_r[j-1][i][DV_N-2:0], 1'b1};
        end else begin
          dr_nxt[j][i] = rt;
          dq_nxt[j][i] = {dq_r[j-1][i][DV_N-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc_c[i] = (dq_r[DV_N][i] > DV_N'(ONE_Q14)) ? DV_N'(ONE_Q14) : dq_r[DV_N][i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mag_c[i];
        neg1_r[i] <= vec_i[i][VEC_W-1];
        mag2_r[i] <= mag1_r[i];
        mn3_r[i]  <= wide_c[i][MN_W-1:0];
        sq4_r[i]  <= (2*MN_W)'(mn3_r[i]) * (2*MN_W)'(mn3_r[i]);
        mn4_r[i]  <= mn3_r[i];
        mnq_r[0][i] <= mn4_r[i];
      end
      orv1_r  <= mag_c[0] | mag_c[1] | mag_c[2];
      neg2_r  <= neg1_r;
      pos2_r  <= pos_c;
      zero2_r <= (orv1_r == '0);
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;

      rad_r[0]  <= SQ_W'(sq4_r[0]) + SQ_W'(sq4_r[1]) + SQ_W'(sq4_r[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      negq_r[0] <= neg4_r;
      zq_r[0]   <= zero4_r;
      for (int k = 1; k <= SQ_N; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        negq_r[k] <= negq_r[k-1];
        zq_r[k]   <= zq_r[k-1];
        for (int i = 0; i < 3; i++) begin
          mnq_r[k][i] <= mnq_r[k-1][i];
        end
      end

      // numerator is mag * 2^14, the top part below the root by construction
      for (int i = 0; i < 3; i++) begin
        dr_r[0][i] <= DVR_W'(mnq_r[SQ_N][i] >> 1);
        nb_r[0][i] <= {mnq_r[SQ_N][i][0], (DV_N-1)'(0)};
        dq_r[0][i] <= '0;
      end
      dlen_r[0] <= root_r[SQ_N];
      dneg_r[0] <= negq_r[SQ_N];
      dz_r[0]   <= zq_r[SQ_N];
      for (int j = 1; j <= DV_N; j++) begin
        for (int i = 0; i < 3; i++) begin
          dr_r[j][i] <= dr_nxt[j][i];
          dq_r[j][i] <= dq_nxt[j][i];
          nb_r[j][i] <= nb_r[j-1][i] << 1;
        end
        dlen_r[j] <= dlen_r[j-1];
        dneg_r[j] <= dneg_r[j-1];
        dz_r[j]   <= dz_r[j-1];
      end

      for (int i = 0; i < 3; i++) begin
        if (dz_r[DV_N]) begin
          unit_r[i] <= '0;
        end else if (dneg_r[DV_N][i]) begin
          unit_r[i] <= -UNIT_W'(qc_c[i]);
        end else begin
          unit_r[i] <= UNIT_W'(qc_c[i]);
        end
      end
    end
  end

  assign unit_o = unit_r;

endmodule
`default_nettype wire

@@ hdl/spotlight_fragment_lighting.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spotlight_fragment_lighting
// per-pixel spotlight shading: barycentric interpolation, normalize, diffuse
// term, smooth cone falloff, ambient, light colour, saturation
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | tvalid/tready      | tuser cmd, tdata vertex + fragment
//  out_    | master    | tvalid/tready      | tdata red, green, blue
//  cfg_    | write     | cfg_we             | cfg_addr register, cfg_wdata value
//
//  one request per cycle in, one result per cycle out while no result is held;
//  the pipeline depth is set by the square root and the two bit-per-stage
//  dividers of the normalize unit and the cone divider
//  load requests write a vertex slot at accept and make no result
//  rst_n is synchronous: valid bits, slots and registers clear, epsilon = 1.0
//  a held result stalls the whole pipeline and in_tready together; nothing
//  is dropped or repeated
//
module spotlight_fragment_lighting
  import spl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // slave request channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,  // vert_slot, norm_x, norm_y, norm_z, pos_x,
                                            // pos_y, pos_z, weight0, weight1, weight2,
                                            // texel_rgb, zero pad
  input  wire logic              in_tuser,  // cmd
  // master result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata, // red, green, blue
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  // ---------------------------------------------------------------- fields
  logic [1:0]  f_slot;
  logic [15:0] f_norm [3];
  logic [19:0] f_pos  [3];
  logic [15:0] f_wgt  [3];
  logic [23:0] f_texel;

  assign f_slot    = in_tdata[1:0];
  assign f_norm[0] = in_tdata[17:2];
  assign f_norm[1] = in_tdata[33:18];
  assign f_norm[2] = in_tdata[49:34];
  assign f_pos[0]  = in_tdata[69:50];
  assign f_pos[1]  = in_tdata[89:70];
  assign f_pos[2]  = in_tdata[109:90];
  assign f_wgt[0]  = in_tdata[125:110];
  assign f_wgt[1]  = in_tdata[141:126];
  assign f_wgt[2]  = in_tdata[157:142];
  assign f_texel   = in_tdata[181:158];

  // ---------------------------------------------------------------- control
  logic en;
  logic in_acc;
  logic out_tvalid_r;

  // the pipeline moves whenever the output register is free or being taken
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------- config
  logic [47:0] light_dir_r;
  logic [59:0] light_pos_r;
  logic [15:0] outer_cos_r;
  logic [15:0] cone_eps_r;
  logic [47:0] light_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_dir_r   <= '0;
      light_pos_r   <= '0;
      outer_cos_r   <= '0;
      cone_eps_r    <= 16'(ONE_Q14);
      light_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_LIGHT_DIR:   light_dir_r   <= cfg_wdata[47:0];
        REG_LIGHT_POS:   light_pos_r   <= cfg_wdata[59:0];
        REG_OUTER_COS:   outer_cos_r   <= cfg_wdata[15:0];
        REG_CONE_EPS:    cone_eps_r    <= cfg_wdata[15:0];
        REG_LIGHT_COLOR: light_color_r <= cfg_wdata[47:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- vertex slots
  logic [47:0] slot_nrm_r [3];
  logic [59:0] slot_pos_r [3];

  // slot three does not exist, such a load is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        slot_nrm_r[k] <= '0;
        slot_pos_r[k] <= '0;
      end
    end else if (in_acc && (cmd_t'(in_tuser) == CMD_LOAD)) begin
      for (int k = 0; k < 3; k++) begin
        if (f_slot == 2'(k)) begin
          slot_nrm_r[k] <= {f_norm[2], f_norm[1], f_norm[0]};
          slot_pos_r[k] <= {f_pos[2], f_pos[1], f_pos[0]};
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage a
  // weighted products read the slots at accept, so loads and shades keep order
  logic               va_r;
  logic signed [32:0] pn_a_r [3][3];
  logic signed [36:0] pp_a_r [3][3];
  logic [23:0]        tex_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_acc && (cmd_t'(in_tuser) == CMD_SHADE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tex_a_r <= f_texel;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pn_a_r[k][i] <= 33'($signed(slot_nrm_r[k][16*i +: 16]))
                          * 33'($signed({1'b0, f_wgt[k]}));
          pp_a_r[k][i] <= 37'($signed(slot_pos_r[k][20*i +: 20]))
                          * 37'($signed({1'b0, f_wgt[k]}));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage b
  // interpolated normal Q.29 and position Q.23
  logic               vb_r;
  logic signed [34:0] nv_b_r [3];
  logic signed [38:0] pv_b_r [3];
  logic [23:0]        tex_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tex_b_r <= tex_a_r;
      for (int i = 0; i < 3; i++) begin
        nv_b_r[i] <= 35'(pn_a_r[0][i]) + 35'(pn_a_r[1][i]) + 35'(pn_a_r[2][i]);
        pv_b_r[i] <= 39'(pp_a_r[0][i]) + 39'(pp_a_r[1][i]) + 39'(pp_a_r[2][i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage c
  // vectors for the three normalize units: normal, light axis, fragment to light
  logic       vc_r;
  vec_comp_t  nv_c_r [3];
  vec_comp_t  lv_c_r [3];
  vec_comp_t  dv_c_r [3];
  logic [23:0] tex_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tex_c_r <= tex_b_r;
      for (int i = 0; i < 3; i++) begin
        nv_c_r[i] <= VEC_W'(nv_b_r[i]);
        lv_c_r[i] <= -VEC_W'($signed(light_dir_r[16*i +: 16]));
        // light position scaled to Q.23
        dv_c_r[i] <= (VEC_W'($signed(light_pos_r[20*i +: 20])) <<< 15) - VEC_W'(pv_b_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------- normalize
  unit_comp_t n_u [3];
  unit_comp_t l_u [3];
  unit_comp_t f_u [3];

  spl_unit3 u_norm_n (.clk(clk), .en(en), .vec_i(nv_c_r), .unit_o(n_u));
  spl_unit3 u_norm_l (.clk(clk), .en(en), .vec_i(lv_c_r), .unit_o(l_u));
  spl_unit3 u_norm_f (.clk(clk), .en(en), .vec_i(dv_c_r), .unit_o(f_u));

  // valid and texel ride alongside the units
  logic        vd_r   [UNIT_LAT];
  logic [23:0] texd_r [UNIT_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < UNIT_LAT; j++) begin
        vd_r[j] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= vc_r;
      for (int j = 1; j < UNIT_LAT; j++) begin
        vd_r[j] <= vd_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      texd_r[0] <= tex_c_r;
      for (int j = 1; j < UNIT_LAT; j++) begin
        texd_r[j] <= texd_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- dot products
  logic               vp1_r;
  logic signed [29:0] pd_r [3];
  logic signed [29:0] pf_r [3];
  logic [23:0]        tex_p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
    end else if (en) begin
      vp1_r <= vd_r[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tex_p1_r <= texd_r[UNIT_LAT-1];
      for (int i = 0; i < 3; i++) begin
        pd_r[i] <= 30'(n_u[i]) * 30'(l_u[i]);
        pf_r[i] <= 30'(f_u[i]) * 30'(l_u[i]);
      end
    end
  end

  // diffuse term and cone numerator
  logic               vp2_r;
  logic signed [31:0] dot_d_c;
  logic signed [33:0] num_c;
  logic [14:0]        diff_c;
  logic [14:0]        diff_p2_r;
  logic signed [33:0] num_p2_r;
  logic [23:0]        tex_p2_r;

  always_comb begin
    dot_d_c = 32'(pd_r[0]) + 32'(pd_r[1]) + 32'(pd_r[2]);
    num_c   = 34'(pf_r[0]) + 34'(pf_r[1]) + 34'(pf_r[2])
              - (34'($signed(outer_cos_r)) <<< 14);
    if (dot_d_c <= 0) begin
      diff_c = '0;
    end else if ((dot_d_c >>> 14) > 32'(ONE_Q14)) begin
      diff_c = 15'(ONE_Q14);
    end else begin
      diff_c = 15'(dot_d_c >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp2_r <= 1'b0;
    end else if (en) begin
      vp2_r <= vp1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_p2_r <= diff_c;
      num_p2_r  <= num_c;
      tex_p2_r  <= tex_p1_r;
    end
  end

  // ---------------------------------------------------------------- cone divide
  // quotient at or above 1.0 saturates up front, the rest needs 14 bits;
  // a zero epsilon saturates every positive numerator
  logic        cv_r    [CD_N+1];
  logic [16:0] cr_r    [CD_N+1];
  logic [CD_N-1:0] cnb_r [CD_N+1];
  logic [CD_N-1:0] cq_r  [CD_N+1];
  logic        csat_r  [CD_N+1];
  logic        cnp_r   [CD_N+1];
  logic [14:0] cdiff_r [CD_N+1];
  logic [23:0] ctex_r  [CD_N+1];
  logic [16:0] cr_nxt  [CD_N+1];
  logic [CD_N-1:0] cq_nxt [CD_N+1];

  always_comb begin
    logic [16:0] rt;
    rt        = '0;
    cr_nxt[0] = '0;
    cq_nxt[0] = '0;
    for (int j = 1; j <= CD_N; j++) begin
      rt = {cr_r[j-1][15:0], cnb_r[j-1][CD_N-1]};
      if (rt >= 17'(cone_eps_r)) begin
        cr_nxt[j] = rt - 17'(cone_eps_r);
        cq_nxt[j] = {cq_r[j-1][CD_N-2:0], 1'b1};
      end else begin
        cr_nxt[j] = rt;
        cq_nxt[j] = {cq_r[j-1][CD_N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= CD_N; j++) begin
        cv_r[j] <= 1'b0;
      end
    end else if (en) begin
      cv_r[0] <= vp2_r;
      for (int j = 1; j <= CD_N; j++) begin
        cv_r[j] <= cv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0]    <= 17'(num_p2_r[30:CD_N]);
      cnb_r[0]   <= num_p2_r[CD_N-1:0];
      cq_r[0]    <= '0;
      csat_r[0]  <= num_p2_r >= (34'(cone_eps_r) << CD_N);
      cnp_r[0]   <= num_p2_r <= 0;
      cdiff_r[0] <= diff_p2_r;
      ctex_r[0]  <= tex_p2_r;
      for (int j = 1; j <= CD_N; j++) begin
        cr_r[j]    <= cr_nxt[j];
        cq_r[j]    <= cq_nxt[j];
        cnb_r[j]   <= cnb_r[j-1] << 1;
        csat_r[j]  <= csat_r[j-1];
        cnp_r[j]   <= cnp_r[j-1];
        cdiff_r[j] <= cdiff_r[j-1];
        ctex_r[j]  <= ctex_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------- cone select
  logic        vk_r;
  logic [14:0] cone_r;
  logic [14:0] diff_k_r;
  logic [23:0] tex_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vk_r <= 1'b0;
    end else if (en) begin
      vk_r <= cv_r[CD_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (cnp_r[CD_N]) begin
        cone_r <= '0;
      end else if (csat_r[CD_N]) begin
        cone_r <= 15'(ONE_Q14);
      end else begin
        cone_r <= 15'(cq_r[CD_N]);
      end
      diff_k_r <= cdiff_r[CD_N];
      tex_k_r  <= ctex_r[CD_N];
    end
  end

  // ---------------------------------------------------------------- colour
  logic        vm_r;
  logic [29:0] dc_r;
  logic [23:0] tex_m_r;
  logic [15:0] factor_c;
  logic        vt_r;
  logic [23:0] tf_r [3];
  logic        vq_r;
  logic [39:0] ch_r [3];
  logic [7:0]  sat_c [3];

  assign factor_c = 16'(dc_r >> 14) + 16'(AMBIENT_Q14);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_c[i] = ((ch_r[i] >> 29) > 40'd255) ? 8'd255 : ch_r[i][36:29];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vt_r <= 1'b0;
      vq_r <= 1'b0;
    end else if (en) begin
      vm_r <= vk_r;
      vt_r <= vm_r;
      vq_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r    <= 30'(diff_k_r) * 30'(cone_r);
      tex_m_r <= tex_k_r;
      for (int i = 0; i < 3; i++) begin
        tf_r[i] <= 24'(tex_m_r[8*i +: 8]) * 24'(factor_c);
        ch_r[i] <= 40'(tf_r[i]) * 40'(light_color_r[16*i +: 16]);
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic [OUT_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {sat_c[2], sat_c[1], sat_c[0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a load request never enters the shading pipeline
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd_t'(in_tuser) == CMD_LOAD)) |=> !va_r)
    else $error("load request entered the pipeline");

  // a load to the missing slot leaves every slot alone
  a_slot3_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd_t'(in_tuser) == CMD_LOAD) && (f_slot == 2'd3)) |=>
    ($stable(slot_nrm_r[0]) && $stable(slot_nrm_r[1]) && $stable(slot_nrm_r[2])
     && $stable(slot_pos_r[0]) && $stable(slot_pos_r[1]) && $stable(slot_pos_r[2])))
    else $error("slot three load changed a slot");

  // cone factor never exceeds one
  a_cone_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vk_r |-> (cone_r <= 15'(ONE_Q14)))
    else $error("cone factor above one");
`endif

endmodule
`default_nettype wire

@@ tb/spotlight_fragment_lighting_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spotlight_fragment_lighting_checker
// watches the request, result and register ports of the spotlight shader,
// predicts each shaded pixel and compares it with what the block returns
// ----------------------------------------------------------------------------
module spotlight_fragment_lighting_checker
  import spl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              in_tuser,
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [OUT_W-1:0]  out_tdata,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  output int                     error_count,
  output int                     pixels_pending
);

  logic [47:0] light_dir;
  logic [59:0] light_pos;
  logic [15:0] outer_cos;
  logic [15:0] cone_eps;
  logic [47:0] light_rgb;
  logic [47:0] vtx_normal [3];
  logic [59:0] vtx_pos [3];
  logic [OUT_W-1:0] pixel_queue [$];

  function automatic longint sx16(input logic [63:0] v);
    return longint'(signed'(v[15:0]));
  endfunction

  function automatic longint sx20(input logic [63:0] v);
    return longint'(signed'(v[19:0]));
  endfunction

  // scale to [2^23, 2^24), integer root, then per-component divide
  function automatic void normalize3(input longint a0, input longint a1, input longint a2,
                                     output longint u0, output longint u1,
                                     output longint u2);
    longint      v [3];
    longint      u [3];
    logic [63:0] m [3];
    bit          ng [3];
    logic [63:0] mx, s, r, bv, q;
    v[0] = a0; v[1] = a1; v[2] = a2;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = v[i] < 0;
      m[i] = ng[i] ? 64'(-v[i]) : 64'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u0 = 0; u1 = 0; u2 = 0;
      return;
    end
    while (mx >= 64'd1 << 24) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < 64'd1 << 23) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = 0;
    bv = 64'd1 << 62;
    while (bv > s) bv = bv >> 2;
    while (bv != 0) begin
      if (s >= r + bv) begin
        s = s - (r + bv);
        r = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << 14) / r;
      if (q > ONE_Q14) q = ONE_Q14;
      u[i] = ng[i] ? -longint'(q) : longint'(q);
    end
    u0 = u[0]; u1 = u[1]; u2 = u[2];
  endfunction

  function automatic logic [OUT_W-1:0] shade_pixel(input logic [IN_W-1:0] d);
    longint      nv [3];
    longint      pv [3];
    longint      lv [3];
    longint      dv [3];
    longint      n [3];
    longint      l [3];
    longint      f [3];
    longint      w [3];
    longint      dot, num, diffuse, cone, factor;
    logic [63:0] c, tex, lc;
    logic [OUT_W-1:0] px;
    w[0] = longint'(d[125:110]);
    w[1] = longint'(d[141:126]);
    w[2] = longint'(d[157:142]);
    for (int i = 0; i < 3; i++) begin
      nv[i] = 0;
      pv[i] = 0;
    end
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) begin
        nv[i] += sx16(64'(vtx_normal[k]) >> (16 * i)) * w[k];
        pv[i] += sx20(64'(vtx_pos[k]) >> (20 * i)) * w[k];
      end
    for (int i = 0; i < 3; i++) begin
      lv[i] = -sx16(64'(light_dir) >> (16 * i));
      dv[i] = sx20(64'(light_pos) >> (20 * i)) * 32768 - pv[i];
    end
    normalize3(nv[0], nv[1], nv[2], n[0], n[1], n[2]);
    normalize3(lv[0], lv[1], lv[2], l[0], l[1], l[2]);
    normalize3(dv[0], dv[1], dv[2], f[0], f[1], f[2]);
    dot = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
    diffuse = dot > 0 ? dot >>> 14 : 0;
    if (diffuse > ONE_Q14) diffuse = ONE_Q14;
    dot = f[0] * l[0] + f[1] * l[1] + f[2] * l[2];
    num = dot - sx16(64'(outer_cos)) * ONE_Q14;
    if (num <= 0) cone = 0;
    else if (cone_eps == 0) cone = ONE_Q14;   // zero epsilon: hard edge
    else begin
      cone = num / longint'(cone_eps);
      if (cone > ONE_Q14) cone = ONE_Q14;
    end
    factor = ((diffuse * cone) >>> 14) + AMBIENT_Q14;
    for (int i = 0; i < 3; i++) begin
      tex = 64'(d[158 + 8 * i +: 8]);
      lc = 64'(light_rgb[16 * i +: 16]);
      c = (tex * 64'(factor) * lc) >> 29;
      if (c > 255) c = 255;
      px[8 * i +: 8] = c[7:0];
    end
    return px;
  endfunction

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (!rst_n) begin
      error_count <= 0;
      light_dir <= '0;
      light_pos <= '0;
      outer_cos <= '0;
      cone_eps  <= 16'd16384;
      light_rgb <= '0;
      for (int k = 0; k < 3; k++) begin
        vtx_normal[k] <= '0;
        vtx_pos[k]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_LIGHT_DIR:   light_dir <= cfg_wdata[47:0];
          REG_LIGHT_POS:   light_pos <= cfg_wdata[59:0];
          REG_OUTER_COS:   outer_cos <= cfg_wdata[15:0];
          REG_CONE_EPS:    cone_eps  <= cfg_wdata[15:0];
          REG_LIGHT_COLOR: light_rgb <= cfg_wdata[47:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (cmd_t'(in_tuser) == CMD_LOAD) begin
          // slot three is ignored
          if (in_tdata[1:0] != 2'd3) begin
            vtx_normal[in_tdata[1:0]] <= in_tdata[49:2];
            vtx_pos[in_tdata[1:0]]    <= in_tdata[109:50];
          end
        end else begin
          pixel_queue.push_back(shade_pixel(in_tdata));
        end
      end
      if (out_tvalid && out_tready) begin
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected pixel %h", $time, out_tdata);
          error_count <= error_count + 1;
        end else begin
          want = pixel_queue.pop_front();
          for (int i = 0; i < 3; i++)
            if (want[8 * i +: 8] !== out_tdata[8 * i +: 8])
              $display("%0t: channel %0d expected %0d actual %0d", $time, i,
                       want[8 * i +: 8], out_tdata[8 * i +: 8]);
          if (want !== out_tdata) error_count <= error_count + 1;
        end
      end
    end
  end

  assign pixels_pending = pixel_queue.size();

endmodule

@@ tb/tb_spotlight_fragment_lighting.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spotlight_fragment_lighting
// drives vertex loads and fragment shades under random idling and result
// stalls through several light setups; the checker scores every pixel
// ----------------------------------------------------------------------------
module tb_spotlight_fragment_lighting;
  import spl_pkg::*;

  localparam int PIPE_LAT  = UNIT_LAT + 25;  // shade request to result
  localparam int STALL_MAX = 4000;           // cycles with no handshake at all

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // vert_slot, norm_x..z, pos_x..z, weight0..2, texel
  logic              in_tuser;   // cmd
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // red, green, blue
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;
  int                error_count;
  int                pixels_pending;
  bit                no_idle;     // stretch with both sides always ready
  int                sent;
  int                quiet_cycles;

  spotlight_fragment_lighting uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  spotlight_fragment_lighting_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .error_count(error_count), .pixels_pending(pixels_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver stalls about 30 percent of the time outside the quiet stretch
  always @(posedge clk)
    out_tready <= no_idle || ($urandom_range(0, 99) >= 30);

  // watchdog: any handshake or register write resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [IN_W-1:0] pack_request(
      input logic [1:0] slot, input logic [15:0] nx, input logic [15:0] ny,
      input logic [15:0] nz, input logic [19:0] px, input logic [19:0] py,
      input logic [19:0] pz, input logic [15:0] w0, input logic [15:0] w1,
      input logic [15:0] w2, input logic [23:0] texel);
    return {2'b00, texel, w2, w1, w0, pz, py, px, nz, ny, nx, slot};
  endfunction

  function automatic logic [15:0] rand_normal();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);   // any bit pattern
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // one request, held until accepted; optional idle gap first
  task automatic send(input cmd_t cmd, input logic [IN_W-1:0] d);
    bit fire;
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do begin
      @(negedge clk);
      fire = in_tready;
      @(posedge clk);
    end while (!fire);
    sent++;
  endtask

  task automatic send_load(input logic [1:0] slot);
    send(CMD_LOAD, pack_request(slot, rand_normal(), rand_normal(), rand_normal(),
                                20'($urandom), 20'($urandom), 20'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom),
                                24'($urandom)));
  endtask

  task automatic send_shade(input bit wild);
    int w0, w1, w2;
    if (wild) begin
      w0 = $urandom_range(0, 65535);
      w1 = $urandom_range(0, 65535);
      w2 = $urandom_range(0, 65535);
    end else begin
      w0 = $urandom_range(0, 32768);
      w1 = $urandom_range(0, 32768 - w0);
      w2 = 32768 - w0 - w1;
    end
    send(CMD_SHADE, pack_request(2'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 20'($urandom), 20'($urandom),
                                 20'($urandom), 16'(w0), 16'(w1), 16'(w2),
                                 24'($urandom)));
  endtask

  // wait out every pending pixel, then the pipeline depth, before writing registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pixels_pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic write_lights(input logic [47:0] dir, input logic [59:0] pos,
                              input logic [15:0] oc, input logic [15:0] eps,
                              input logic [47:0] rgb);
    logic [CFG_W-1:0] val [5];
    val[0] = 60'(dir); val[1] = pos; val[2] = 60'(oc); val[3] = 60'(eps);
    val[4] = 60'(rgb);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_reg_t'(i);
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] rand_dir();
    return {rand_normal(), rand_normal(), rand_normal()};
  endfunction

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = CMD_LOAD;
    out_tready = 1'b0; cfg_we = 1'b0; cfg_addr = REG_LIGHT_DIR; cfg_wdata = '0;
    no_idle = 1'b0; sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // shade straight out of reset: zero slots and zero light
    send_shade(1'b0);
    drain();
    // light straight down onto a floor, full white
    write_lights({16'hC000, 16'h0000, 16'h0000}, {20'h00A00, 20'h00000, 20'h00000},
                 16'hC000, 16'd32768, 48'hFFFF_FFFF_FFFF);
    send(CMD_LOAD, pack_request(2'd0, 16'd0, 16'd0, 16'd16384, 20'h7FFFF, 20'h80000,
                                20'h0, '0, '0, '0, '0));
    send(CMD_LOAD, pack_request(2'd1, 16'hC000, 16'hC000, 16'hC000, 20'h80000,
                                20'h7FFFF, 20'h0, '0, '0, '0, '0));
    send(CMD_LOAD, pack_request(2'd2, 16'h4000, 16'h4000, 16'h4000, 20'h0, 20'h0,
                                20'hFFFFF, '0, '0, '0, '0));
    // slot three load must not disturb anything
    send(CMD_LOAD, pack_request(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF,
                                20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                24'hFFFFFF));
    send(CMD_SHADE, pack_request('0, '0, '0, '0, '0, '0, '0, 16'd32768, '0, '0,
                                 24'hFFFFFF));
    send(CMD_SHADE, pack_request('0, '0, '0, '0, '0, '0, '0, '0, 16'd32768, '0,
                                 24'h000000));
    send(CMD_SHADE, pack_request('0, '0, '0, '0, '0, '0, '0, '0, '0, 16'd32768,
                                 24'h80FF01));
    // zero weights: zero normal
    send(CMD_SHADE, pack_request('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 24'hFFFFFF));
    send(CMD_SHADE, pack_request(2'd3, '1, '1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 24'hFFFFFF));
    send(CMD_SHADE, pack_request('0, '0, '0, '0, '0, '0, '0, 16'd10923, 16'd10923,
                                 16'd10922, 24'h7F7F7F));
    drain();
    // zero epsilon and the opposite cone extreme
    write_lights(48'h0, 60'h0, 16'd16384, 16'd0, 48'h8000_8000_8000);
    send_shade(1'b0);
    send_shade(1'b0);
    drain();
    write_lights(rand_dir(), 60'($urandom) << 30 | 60'($urandom), 16'hC000, 16'd0,
                 48'hFFFF_FFFF_FFFF);
    send_shade(1'b0);
    send_shade(1'b1);

    // random phases, each under its own light setup
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_lights(rand_dir(), {40'($urandom), 20'($urandom)}, 16'hC000, 16'd1,
                        48'hFFFF_FFFF_FFFF);
        1: write_lights(rand_dir(), {40'($urandom), 20'($urandom)}, 16'd16384,
                        16'd32768, {16'($urandom), 16'($urandom), 16'($urandom)});
        2: write_lights('1, '1, '1, '1, '1);
        default: write_lights({16'($urandom), 32'($urandom)},
                              {$urandom, 28'($urandom)},
                              16'($urandom_range(0, 32768) - 16384),
                              16'($urandom_range(1, 32768)),
                              {16'($urandom), 32'($urandom)});
      endcase
      no_idle = (ph == 1);
      for (int n = 0; n < 220; ) begin
        case ($urandom_range(0, 9))
          0: begin
            send_load(2'($urandom));   // stray load, maybe slot three
            n++;
          end
          1: begin
            send_shade(1'b1);
            n++;
          end
          default: begin
            for (int s = 0; s < 3; s++) send_load(2'(s));
            repeat ($urandom_range(1, 6)) begin
              send_shade(1'b0);
              n++;
            end
            n += 3;
          end
        endcase
      end
      no_idle = 1'b0;
    end

    drain();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
